// ===== design/bmh_pkg.sv =====
// bmh_pkg: shared constants, codes and request/result types of the binary max-heap.
// Used by bmh_engine, binary_max_heap and binary_max_heap_checker; depends on nothing.
`default_nettype none

package bmh_pkg;

    // Store depth and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;

    // Operation codes
    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // One request as it enters the engine
    typedef struct packed {
        kind_t                    kind;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // One result as it leaves the engine
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        status_t                  status;
    } res_t;

endpackage

`default_nettype wire

// ===== design/bmh_ram.sv =====
// bmh_ram: generic synchronous RAM, one write port, two registered read ports.
// Self-contained; read during a write to the same address returns the old data.
`default_nettype none

module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/bmh_engine.sv =====
// bmh_engine: heap sequencer; sifts values up or down through the store RAM.
// Depends on bmh_pkg and bmh_ram.
`default_nettype none

module bmh_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire bmh_pkg::req_t req,
    output logic               idle,
    output logic               res_valid,
    input  wire logic          res_ready,
    output bmh_pkg::res_t      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_LAST_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [bmh_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bmh_pkg::CNT_W-1:0]         pos_reg, pos_next;
    logic signed [bmh_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic signed [bmh_pkg::DATA_W-1:0] top_reg, top_next;
    bmh_pkg::status_t                  status_reg, status_next;

    // RAM port signals
    logic                              mem_we;
    logic [bmh_pkg::ADDR_W-1:0]        mem_waddr;
    logic [bmh_pkg::DATA_W-1:0]        mem_wdata;
    logic [bmh_pkg::ADDR_W-1:0]        mem_raddr_a, mem_raddr_b;
    logic [bmh_pkg::DATA_W-1:0]        mem_rdata_a, mem_rdata_b;
    logic signed [bmh_pkg::DATA_W-1:0] rd_a, rd_b;

    // Tree arithmetic (one-based positions)
    logic [bmh_pkg::CNT_W:0]           lft, rgt;
    logic [bmh_pkg::CNT_W-1:0]         par;
    logic                              use_rgt;
    logic signed [bmh_pkg::DATA_W-1:0] sel_val;
    logic [bmh_pkg::CNT_W-1:0]         sel_pos;

    bmh_ram #(
        .WIDTH(bmh_pkg::DATA_W),
        .DEPTH(bmh_pkg::CAPACITY)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr_a(mem_raddr_a),
        .rdata_a(mem_rdata_a),
        .raddr_b(mem_raddr_b),
        .rdata_b(mem_rdata_b)
    );

    assign rd_a = $signed(mem_rdata_a);
    assign rd_b = $signed(mem_rdata_b);

    assign lft     = {pos_reg, 1'b0};
    assign rgt     = lft + (bmh_pkg::CNT_W+1)'(1);
    assign par     = pos_reg >> 1;
    // right child only when it exists and the left one is strictly smaller
    assign use_rgt = (rgt <= {1'b0, cnt_reg}) && (rd_a < rd_b);
    assign sel_val = use_rgt ? rd_b : rd_a;
    assign sel_pos = use_rgt ? rgt[bmh_pkg::CNT_W-1:0] : lft[bmh_pkg::CNT_W-1:0];

    // Next-state and RAM control
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        top_next    = top_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = bmh_pkg::ADDR_W'(pos_reg - bmh_pkg::CNT_W'(1));
        mem_wdata   = cur_reg;
        mem_raddr_a = bmh_pkg::ADDR_W'(par - bmh_pkg::CNT_W'(1));
        mem_raddr_b = lft[bmh_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                status_next = bmh_pkg::ST_OK;
                mem_raddr_a = bmh_pkg::ADDR_W'(cnt_reg - bmh_pkg::CNT_W'(1));
                if (req_valid) begin
                    if (req.kind == bmh_pkg::KIND_POP) begin
                        if (cnt_reg == '0) begin
                            status_next = bmh_pkg::ST_POP_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            // last entry read issued now, lands in S_LAST_LD
                            cnt_next   = cnt_reg - bmh_pkg::CNT_W'(1);
                            state_next = S_LAST_LD;
                        end
                    end else begin
                        if (cnt_reg >= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY)) begin
                            status_next = bmh_pkg::ST_PUSH_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cur_next   = req.value;
                            cnt_next   = cnt_reg + bmh_pkg::CNT_W'(1);
                            pos_next   = cnt_reg + bmh_pkg::CNT_W'(1);
                            state_next = S_UP_RD;
                        end
                    end
                end
            end

            // Sift up: fetch parent, or settle at the root
            S_UP_RD: begin
                if (pos_reg == bmh_pkg::CNT_W'(1)) begin
                    mem_we     = 1'b1;
                    top_next   = cur_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end

            // Parent not smaller: place value; else move parent down into the hole
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (rd_a >= cur_reg) begin
                    state_next = S_DONE;
                end else begin
                    mem_wdata  = rd_a;
                    pos_next   = par;
                    state_next = S_UP_RD;
                end
            end

            // Last entry becomes the value sifted down from the root
            S_LAST_LD: begin
                cur_next = rd_a;
                pos_next = bmh_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RD;
                end
            end

            // Sift down: fetch both children, or settle at a leaf
            S_DN_RD: begin
                mem_raddr_a = bmh_pkg::ADDR_W'(lft - (bmh_pkg::CNT_W+1)'(1));
                if (lft > {1'b0, cnt_reg}) begin
                    mem_we = 1'b1;
                    if (pos_reg == bmh_pkg::CNT_W'(1)) begin
                        top_next = cur_reg;
                    end
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_CMP;
                end
            end

            // Node not smaller than chosen child: place it; else pull child up
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (cur_reg >= sel_val) begin
                    if (pos_reg == bmh_pkg::CNT_W'(1)) begin
                        top_next = cur_reg;
                    end
                    state_next = S_DONE;
                end else begin
                    mem_wdata = sel_val;
                    if (pos_reg == bmh_pkg::CNT_W'(1)) begin
                        top_next = sel_val;
                    end
                    pos_next   = sel_pos;
                    state_next = S_DN_RD;
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            status_reg <= bmh_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        top_reg <= top_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    // Result fields
    always_comb begin
        res.is_empty  = (cnt_reg == '0);
        res.top_value = res.is_empty ? '0 : top_reg;
        res.count     = bmh_pkg::COUNT_W'(cnt_reg);
        res.status    = status_reg;
    end

endmodule

`default_nettype wire

// ===== design/binary_max_heap.sv =====
// binary_max_heap: top level; request intake and registered result output.
// Depends on bmh_pkg and bmh_engine (which holds the store RAM).
`default_nettype none

// A max-heap priority queue of up to 1024 signed 32-bit values. Each request
// (s_kind 0 = push s_value, 1 = pop the maximum) yields one result carrying the
// new top, the count, an empty flag and a status (pop on empty and push on full
// leave the heap unchanged and are flagged). One request is worked at a time:
// the store is a RAM with a registered read, and each tree level takes a read
// and a compare/write-back. A push moves its value up at most 10 levels and a
// pop moves the node down at most 9. A request is taken only in the idle state,
// which the engine enters once its result has gone to the output register. A
// result waiting in the output register does not hold up the engine; once a
// second result is ready, no request is taken until the first one has been
// accepted.
module binary_max_heap (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_kind,
    input  wire logic signed [bmh_pkg::DATA_W-1:0] s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [bmh_pkg::DATA_W-1:0]      m_top_value,
    output logic [bmh_pkg::COUNT_W-1:0]           m_count,
    output logic                                  m_is_empty,
    output logic [1:0]                            m_status
);

    bmh_pkg::req_t req;
    bmh_pkg::res_t res;
    logic          eng_idle;
    logic          res_valid;
    logic          res_ready;
    logic          m_valid_reg;
    bmh_pkg::res_t m_res_reg;

    assign req.kind  = bmh_pkg::kind_t'(s_kind);
    assign req.value = s_value;

    bmh_engine u_engine (
        .clk      (aclk),
        .rst_n    (aresetn),
        .req_valid(s_valid),
        .req      (req),
        .idle     (eng_idle),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign s_ready   = eng_idle;
    assign res_ready = !m_valid_reg || m_ready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = m_res_reg.top_value;
    assign m_count     = m_res_reg.count;
    assign m_is_empty  = m_res_reg.is_empty;
    assign m_status    = m_res_reg.status;

endmodule

`default_nettype wire

// ===== design/binary_max_heap_checker.sv =====
// binary_max_heap_checker: port-level assertions for binary_max_heap, bound to it.
// Depends on bmh_pkg and binary_max_heap.
`default_nettype none

module binary_max_heap_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [bmh_pkg::DATA_W-1:0] m_top_value,
    input wire logic [bmh_pkg::COUNT_W-1:0]       m_count,
    input wire logic                              m_is_empty,
    input wire logic [1:0]                        m_status
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value) && $stable(m_count)
                               && $stable(m_status))
        else $error("result changed while stalled");

    // Empty flag agrees with count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");

    // Empty heap shows zero top
    a_zero_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_top_value == '0)
        else $error("non-zero top on empty heap");

    // Pop on empty only when empty
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bmh_pkg::ST_POP_EMPTY |-> m_is_empty)
        else $error("pop-on-empty flagged with data present");

    // Push dropped only when full
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bmh_pkg::ST_PUSH_FULL
            |-> m_count == bmh_pkg::COUNT_W'(bmh_pkg::CAPACITY))
        else $error("push-on-full flagged below capacity");

endmodule

bind binary_max_heap binary_max_heap_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_top_value(m_top_value),
    .m_count    (m_count),
    .m_is_empty (m_is_empty),
    .m_status   (m_status)
);

`default_nettype wire

// ===== sim/binary_max_heap_checker.sv =====
// heap_scoreboard: watches both channels of the heap, keeps its own copy
// of the heap to predict each result and compares every delivered result with it.
// Depends on bmh_pkg for widths, codes and the result type.
`timescale 1ns / 1ps

module heap_scoreboard
    import bmh_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic                      s_kind,
    input  wire logic signed [DATA_W-1:0]  s_value,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic signed [DATA_W-1:0]  m_top_value,
    input  wire logic [COUNT_W-1:0]        m_count,
    input  wire logic                      m_is_empty,
    input  wire logic [1:0]                m_status,
    output int                             fail_count,
    output int                             pending,
    output int                             heap_size
);

    // Shadow heap, one-based positions mapped onto zero-based slots
    logic signed [DATA_W-1:0] heap_mirror [CAPACITY];
    int unsigned              mirror_size;
    res_t                     due_results [$];

    // Swap two slots of the shadow heap
    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [DATA_W-1:0] tmp;
        tmp            = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = tmp;
    endfunction

    // Apply one request to the shadow heap and return the result it yields
    function automatic res_t apply_heap_request(kind_t kind, logic signed [DATA_W-1:0] value);
        res_t        outcome;
        int unsigned pos;
        int unsigned par;
        int unsigned lft;
        int unsigned sel;
        outcome.status = ST_OK;
        if (kind == KIND_POP) begin
            if (mirror_size == 0) begin
                outcome.status = ST_POP_EMPTY;
            end else begin
                // last entry to the root, then sift down towards the larger child
                heap_mirror[0] = heap_mirror[mirror_size - 1];
                mirror_size--;
                pos = 1;
                while (2 * pos <= mirror_size) begin
                    lft = 2 * pos;
                    sel = lft;
                    if (lft + 1 <= mirror_size && heap_mirror[lft - 1] < heap_mirror[lft])
                        sel = lft + 1;
                    if (heap_mirror[pos - 1] >= heap_mirror[sel - 1])
                        break;
                    swap_slots(pos - 1, sel - 1);
                    pos = sel;
                end
            end
        end else begin
            if (mirror_size >= CAPACITY) begin
                outcome.status = ST_PUSH_FULL;
            end else begin
                // append, then sift up while strictly above the parent
                heap_mirror[mirror_size] = value;
                mirror_size++;
                pos = mirror_size;
                while (pos > 1) begin
                    par = pos / 2;
                    if (heap_mirror[par - 1] >= heap_mirror[pos - 1])
                        break;
                    swap_slots(par - 1, pos - 1);
                    pos = par;
                end
            end
        end
        outcome.top_value = (mirror_size == 0) ? '0 : heap_mirror[0];
        outcome.count     = COUNT_W'(mirror_size);
        outcome.is_empty  = (mirror_size == 0);
        return outcome;
    endfunction

    // Compare delivered results, then predict for the request accepted at this edge
    always @(posedge aclk) begin : watch_channels
        res_t got;
        res_t want;
        int   errs;
        errs = 0;
        if (!aresetn) begin
            due_results.delete();
            mirror_size = 0;
            fail_count <= 0;
            pending    <= 0;
            heap_size  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.top_value = m_top_value;
                got.count     = m_count;
                got.is_empty  = m_is_empty;
                got.status    = status_t'(m_status);
                if (due_results.size() == 0) begin
                    $error("result delivered with no request outstanding");
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    if (got.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
                        errs++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        errs++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                        errs++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errs++;
                    end
                end
            end
            // queue the prediction behind those still outstanding
            if (s_valid && s_ready)
                due_results.insert(due_results.size(),
                                   apply_heap_request(kind_t'(s_kind), s_value));
            fail_count <= fail_count + errs;
            pending    <= due_results.size();
            heap_size  <= mirror_size;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: clock, reset and request stimulus for binary_max_heap, with phased idling.
// Depends on bmh_pkg, binary_max_heap and heap_scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import bmh_pkg::*;

    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 60;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_kind  = 1'b0;
    logic signed [DATA_W-1:0]  s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_top_value;
    logic [COUNT_W-1:0]        m_count;
    logic                      m_is_empty;
    logic [1:0]                m_status;

    int   fail_count;
    int   pending;
    int   heap_size;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_seen      = 1'b0;
    int   hold_left      = 0;

    always #1 aclk = ~aclk;

    binary_max_heap dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_status    (m_status)
    );

    heap_scoreboard heap_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_status    (m_status),
        .fail_count  (fail_count),
        .pending     (pending),
        .heap_size   (heap_size)
    );

    // Result side: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Value mix: small range for ties, the extremes, and full-range noise
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return int'($urandom_range(15)) - 8;
            1: begin
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offer one request; valid stays up across back-to-back requests
    task automatic send_request(input kind_t kind, input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_mixed(input int n, input int push_pct);
        repeat (n) begin
            if ($urandom_range(99) < push_pct)
                send_request(KIND_PUSH, pick_value());
            else
                send_request(KIND_POP, pick_value());
        end
    endtask

    // Stop offering and wait until every predicted result has been delivered
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: pop on empty, extremes, ties, emptying out, single entry
        send_request(KIND_POP, 32'h1234_5678);
        send_request(KIND_PUSH, 32'h7FFF_FFFF);
        send_request(KIND_PUSH, 32'h8000_0000);
        send_request(KIND_PUSH, 32'h0000_0000);
        send_request(KIND_PUSH, 32'hFFFF_FFFF);
        send_request(KIND_PUSH, 32'h0000_0001);
        send_request(KIND_PUSH, 32'h0000_0005);
        send_request(KIND_PUSH, 32'h0000_0005);
        send_request(KIND_PUSH, 32'h0000_0005);
        send_request(KIND_PUSH, 32'hFFFF_FFFF);
        repeat (9) send_request(KIND_POP, 32'hFFFF_FFFF);
        send_request(KIND_POP, '0);
        send_request(KIND_PUSH, 32'h8000_0000);
        send_request(KIND_POP, '0);
        wait_drained();

        // Random phases under different idling
        run_mixed(150, 50);
        wait_drained();
        send_idle_pct  = 59;
        run_mixed(150, 60);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 59;
        run_mixed(150, 60);
        wait_drained();

        // Long result hold-off while requests keep coming, so the input backs up
        recv_stall_pct = 6;
        send_idle_pct  = 6;
        hold_req <= ~hold_req;
        run_mixed(100, 60);
        wait_drained();

        // Fill to capacity for full-depth sifts, then a few pushes on full
        while (heap_size < CAPACITY) send_request(KIND_PUSH, pick_value());
        repeat (6) send_request(KIND_PUSH, pick_value());
        wait_drained();

        // Mixed traffic hovering around full
        recv_stall_pct = 59;
        send_idle_pct  = 0;
        run_mixed(150, 50);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
